### hw/rtl/console_controller_registers_assert.svh
// Assertion macros shared by the console controller RTL files.
`ifndef CONSOLE_CONTROLLER_REGISTERS_ASSERT_SVH
`define CONSOLE_CONTROLLER_REGISTERS_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CCR_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CCR_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/ccr_pkg.sv
// Package of types and constants for the console controller registers.
package ccr_pkg;

    localparam int CCR_FIFO_DEPTH = 64;
    localparam int CMD_W          = 3;
    localparam int WORD_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int OUT_W          = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA_WR = 3'd0,
        CMD_CTRL_WR = 3'd1,
        CMD_DATA_RD = 3'd2,
        CMD_STAT_RD = 3'd3,
        CMD_LINE_RX = 3'd4,
        CMD_TX_PULL = 3'd5
    } t_cmd;

    // status word bits
    localparam logic [WORD_W-1:0] ST_EXISTS = 16'h8000;
    localparam logic [WORD_W-1:0] ST_BUSY   = 16'h0100;
    localparam logic [WORD_W-1:0] ST_NRDY   = 16'h0080;

    // command word class field (bits 15:14) and flag bit positions
    localparam logic [1:0] CLS_CTRL    = 2'b01;
    localparam logic [1:0] CLS_XFER    = 2'b10;
    localparam int         B_DI_BIT    = 13;
    localparam int         B_SI_BIT    = 12;
    localparam int         B_DIRRD_BIT = 11;
    localparam int         B_TERM_BIT  = 10;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
    } t_fifo_stat;

    // result of the decode stage, completed with memory read data in the following cycle
    typedef struct packed {
        logic [WORD_W-1:0] rv;
        logic [BYTE_W-1:0] txb;
        logic              sel_rx;
        logic              sel_tx;
        logic              si;
        logic              di;
        logic              txv;
        logic              acc;
        logic              ovf;
    } t_pre;

endpackage

### hw/rtl/ccr_fifo.sv
// Byte FIFO built on a synchronous memory with a registered read port.
`include "console_controller_registers_assert.svh"
module ccr_fifo #(
    parameter int DEPTH = ccr_pkg::CCR_FIFO_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_pop,
    input  logic [ccr_pkg::BYTE_W-1:0] i_wdata,
    input  logic                      i_rd_en,
    output ccr_pkg::t_fifo_stat       o_stat,
    output logic [ccr_pkg::BYTE_W-1:0] o_rdata
);
    import ccr_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [PtrW-1:0]   r_head, n_head, r_tail, n_tail;
    logic [CntW-1:0]   r_count, n_count;
    logic [BYTE_W-1:0] r_rdata;
    logic              push_ok, pop_ok;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CntW'(DEPTH));
    assign o_stat.one   = (r_count == CntW'(1));
    assign push_ok      = i_push && !o_stat.full;
    assign pop_ok       = i_pop && !o_stat.empty;
    assign o_rdata      = r_rdata;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (push_ok) begin
            n_tail  = (r_tail == PtrW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = n_count + 1'b1;
        end
        if (pop_ok) begin
            n_head  = (r_head == PtrW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            mem[r_tail] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    `CCR_ASSERT_IMP(a_count_range, 1'b1, r_count <= CntW'(DEPTH))
    `CCR_ASSERT_NXT(a_full_drop, i_push && o_stat.full && !i_pop, $stable(r_count))
    `CCR_ASSERT_NXT(a_empty_pop, i_pop && o_stat.empty && !i_push, r_count == '0)

endmodule

### hw/rtl/ccr_ctrl.sv
// Command decode, status and enable registers, FIFO push and pop control.
`include "console_controller_registers_assert.svh"
module ccr_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [ccr_pkg::CMD_W-1:0]  i_cmd,
    input  logic [ccr_pkg::WORD_W-1:0] i_data_word,
    input  ccr_pkg::t_fifo_stat        i_rx_stat,
    input  ccr_pkg::t_fifo_stat        i_tx_stat,
    output logic                       o_rx_push,
    output logic                       o_rx_pop,
    output logic                       o_tx_push,
    output logic                       o_tx_pop,
    output ccr_pkg::t_pre              o_pre
);
    import ccr_pkg::*;

    logic r_busy, n_busy, r_nrdy, n_nrdy;
    logic r_si_en, n_si_en, r_di_en, n_di_en;
    logic r_rd, n_rd, r_wr, n_wr;
    logic new_si, new_di;
    logic [1:0] cls;

    assign cls    = i_data_word[WORD_W-1 -: 2];
    assign new_si = i_data_word[B_SI_BIT];
    assign new_di = i_data_word[B_DI_BIT];

    always_comb begin
        n_busy    = r_busy;
        n_nrdy    = r_nrdy;
        n_si_en   = r_si_en;
        n_di_en   = r_di_en;
        n_rd      = r_rd;
        n_wr      = r_wr;
        o_rx_push = 1'b0;
        o_rx_pop  = 1'b0;
        o_tx_push = 1'b0;
        o_tx_pop  = 1'b0;
        o_pre     = '0;
        if (i_accept) begin
            unique case (t_cmd'(i_cmd))
                CMD_DATA_WR: begin
                    o_tx_push = !i_tx_stat.full;
                    o_pre.ovf = i_tx_stat.full;
                    // transmit side is never empty after this word
                    if (r_wr) begin
                        n_nrdy = 1'b1;
                    end
                end
                CMD_CTRL_WR: begin
                    if (cls == CLS_CTRL) begin
                        if (i_data_word[B_TERM_BIT]) begin
                            n_rd     = 1'b0;
                            n_wr     = 1'b0;
                            n_nrdy   = 1'b1;
                            n_busy   = 1'b0;
                            o_pre.si = r_si_en;
                        end else begin
                            o_pre.si = r_si_en || new_si;
                            n_si_en  = new_si;
                            n_di_en  = new_di;
                        end
                    end else if (cls == CLS_XFER) begin
                        if (!i_data_word[B_DIRRD_BIT]) begin
                            o_pre.di = (r_di_en || new_di) && !r_wr;
                            n_rd     = 1'b0;
                            n_wr     = 1'b1;
                        end else begin
                            n_rd = 1'b1;
                            n_wr = 1'b0;
                        end
                        n_busy  = 1'b1;
                        n_si_en = new_si;
                        n_di_en = new_di;
                    end
                    if (n_rd) begin
                        n_nrdy = i_rx_stat.empty;
                    end
                    if (n_wr) begin
                        n_nrdy = i_tx_stat.full;
                    end
                end
                CMD_DATA_RD: begin
                    o_rx_pop     = !i_rx_stat.empty;
                    o_pre.sel_rx = !i_rx_stat.empty;
                    if (r_rd && (i_rx_stat.empty || i_rx_stat.one)) begin
                        n_nrdy = 1'b1;
                    end
                end
                CMD_STAT_RD: begin
                    if (r_rd) begin
                        n_nrdy = i_rx_stat.empty;
                    end
                    if (r_wr) begin
                        n_nrdy = !i_tx_stat.empty;
                    end
                    o_pre.rv = ST_EXISTS | (r_busy ? ST_BUSY : '0) | (n_nrdy ? ST_NRDY : '0);
                end
                CMD_LINE_RX: begin
                    if (r_rd && i_rx_stat.empty) begin
                        o_rx_push = !i_rx_stat.full;
                        o_pre.acc = !i_rx_stat.full;
                        n_nrdy    = 1'b0;
                        o_pre.di  = r_di_en;
                        o_pre.txv = 1'b1;
                        o_pre.txb = i_data_word[BYTE_W-1:0];
                    end
                end
                CMD_TX_PULL: begin
                    if (!i_tx_stat.empty) begin
                        o_tx_pop     = 1'b1;
                        o_pre.sel_tx = 1'b1;
                        o_pre.txv    = 1'b1;
                        if (i_tx_stat.one && r_wr) begin
                            n_nrdy   = 1'b0;
                            o_pre.di = r_di_en;
                        end
                    end else if (r_wr) begin
                        n_nrdy = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_nrdy  <= 1'b1;
            r_si_en <= 1'b0;
            r_di_en <= 1'b0;
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_nrdy  <= n_nrdy;
            r_si_en <= n_si_en;
            r_di_en <= n_di_en;
            r_rd    <= n_rd;
            r_wr    <= n_wr;
        end
    end

    `CCR_ASSERT_IMP(a_dir_excl, 1'b1, !(r_rd && r_wr))

endmodule

### hw/rtl/console_controller_registers.sv
// Top level of the console controller registers: stream ports, FIFOs and result pipeline.
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+------------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: data_word[15:0]; tuser: cmd[2:0]
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: read_value, service_irq, data_irq,
//          |     |                               |   line_tx_valid, line_tx_byte,
//          |     |                               |   rx_accepted, overflow, zero pad
//
// One word is accepted per cycle unless m_axis back-pressure holds the read stage full;
// its result moves through the read stage, where the registered FIFO read data joins it, and then the output register.
// Status and enable registers update at the accept edge, so back-to-back words
// see each other's effects with no bubble. Reset (i_rst_n low, synchronous)
// holds s_axis_tready low, empties both FIFOs, restores status 0x8080 and drops
// all pending results. When m_axis stalls, one more word is taken into the read
// stage; then s_axis_tready drops until the output register is drained.
`include "console_controller_registers_assert.svh"
module console_controller_registers #(
    parameter int FIFO_DEPTH = ccr_pkg::CCR_FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ccr_pkg::WORD_W-1:0] s_axis_tdata,  // [15:0] data_word
    input  logic [ccr_pkg::CMD_W-1:0]  s_axis_tuser,  // [2:0] cmd
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [15:0] read_value, [16] service_irq, [17] data_irq, [18] line_tx_valid,
    // [26:19] line_tx_byte, [27] rx_accepted, [28] overflow, [31:29] zero
    output logic [ccr_pkg::OUT_W-1:0]  m_axis_tdata
);
    import ccr_pkg::*;

    logic              accept, s2_move;
    logic              rx_push, rx_pop, tx_push, tx_pop;
    t_fifo_stat        rx_stat, tx_stat;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;
    t_pre              pre;
    t_pre              r_s2;
    logic              r_s2_valid;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out, n_out;
    logic [WORD_W-1:0] rv_fin;
    logic [BYTE_W-1:0] txb_fin;

    // Take a word whenever the read stage is free or can move on; hold off in reset.
    assign s_axis_tready = i_rst_n && (!r_s2_valid || !r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s2_move       = r_s2_valid && (!r_out_valid || m_axis_tready);

    ccr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (s_axis_tuser),
        .i_data_word (s_axis_tdata),
        .i_rx_stat   (rx_stat),
        .i_tx_stat   (tx_stat),
        .o_rx_push   (rx_push),
        .o_rx_pop    (rx_pop),
        .o_tx_push   (tx_push),
        .o_tx_pop    (tx_pop),
        .o_pre       (pre)
    );

    // The head entry is read on every accepted word; a pop picks it up in the read stage.
    ccr_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rx_push),
        .i_pop   (rx_pop),
        .i_wdata (s_axis_tdata[BYTE_W-1:0]),
        .i_rd_en (accept),
        .o_stat  (rx_stat),
        .o_rdata (rx_rdata)
    );

    ccr_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tx_push),
        .i_pop   (tx_pop),
        .i_wdata (s_axis_tdata[BYTE_W-1:0]),
        .i_rd_en (accept),
        .o_stat  (tx_stat),
        .o_rdata (tx_rdata)
    );

    // Merge popped bytes into the result.
    assign rv_fin  = r_s2.sel_rx ? {{(WORD_W-BYTE_W){1'b0}}, rx_rdata} : r_s2.rv;
    assign txb_fin = r_s2.sel_tx ? tx_rdata : r_s2.txb;
    assign n_out   = {3'b000, r_s2.ovf, r_s2.acc, txb_fin, r_s2.txv,
                      r_s2.di, r_s2.si, rv_fin};

    // Hold the read stage payload while stalled; load only on accept.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2 <= pre;
        end
        if (s2_move) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s2_valid <= 1'b1;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `CCR_ASSERT_IMP(a_full_stall, r_s2_valid && r_out_valid && !m_axis_tready, !s_axis_tready)

endmodule

### test/console_controller_registers_test.sv
// Self-checking testbench for the console controller registers block.
`timescale 1ns / 100ps

module console_controller_registers_test;
    import ccr_pkg::*;

    // Status bit and command word fields not named by the package.
    localparam logic [WORD_W-1:0] ST_BREAK   = 16'h0020;
    localparam int                BRKSEL_BIT = 8;
    localparam int                BRKDET_BIT = 5;
    localparam int                SIREL_BIT  = 2;

    // Stream codes beyond the defined commands; the block must ignore them.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off for the fill-up test
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either stream
    localparam int TAIL_CYCLES    = 8;     // settle time after the last result
    localparam int MAX_PRINTED    = 40;

    // One result word as it leaves on m_axis, highest bits first.
    typedef struct packed {
        logic [2:0]        pad;
        logic              ovf;
        logic              acc;
        logic [BYTE_W-1:0] txb;
        logic              txv;
        logic              di;
        logic              si;
        logic [WORD_W-1:0] rv;
    } t_console_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [WORD_W-1:0]  s_axis_tdata = '0;   // [15:0] data_word
    logic [CMD_W-1:0]   s_axis_tuser = '0;   // [2:0] cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;        // [15:0] read_value, [16] si, [17] di,
                                             // [18] tx valid, [26:19] tx byte,
                                             // [27] rx accepted, [28] overflow, [31:29] 0

    // Traffic shaping knobs, percent per cycle.
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_stall_pct = 0;

    logic        hold_start = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;

    t_console_result expected_results[$];

    // Shadow copy of the controller state.
    logic [WORD_W-1:0] shadow_status = ST_EXISTS | ST_NRDY;
    logic              shadow_si_en = 1'b0;
    logic              shadow_di_en = 1'b0;
    logic              shadow_reading = 1'b0;
    logic              shadow_writing = 1'b0;
    logic              shadow_break_on = 1'b0;
    logic [BYTE_W-1:0] rx_bytes[$];
    logic [BYTE_W-1:0] tx_bytes[$];

    console_controller_registers i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Decode a command write against the shadow state; return si/di in res.
    function automatic void apply_command(input logic [WORD_W-1:0] w,
                                          inout t_console_result res);
        logic [WORD_W-1:0] st;
        logic              new_si;
        logic              new_di;
        st     = shadow_status;
        new_si = w[B_SI_BIT];
        new_di = w[B_DI_BIT];
        if (w[15:14] == CLS_CTRL) begin
            if (w[B_TERM_BIT]) begin
                // terminate: drop both directions, mark not ready and idle
                shadow_reading = 1'b0;
                shadow_writing = 1'b0;
                st = (st | ST_NRDY) & ~ST_BUSY;
                if (shadow_si_en) res.si = 1'b1;
            end else begin
                // no-op: clear break whenever any non-busy status bit is set
                if ((st & ~ST_BUSY) != '0) st = st & ~ST_BREAK;
                if (w[BRKSEL_BIT]) begin
                    if (!w[BRKDET_BIT] && !w[SIREL_BIT]) shadow_break_on = 1'b0;
                    else if (w[BRKDET_BIT]) shadow_break_on = 1'b1;
                    st = st & ~ST_BREAK;
                end
                if (shadow_si_en || new_si) res.si = 1'b1;
                shadow_si_en = new_si;
                shadow_di_en = new_di;
            end
        end else if (w[15:14] == CLS_XFER) begin
            if (!w[B_DIRRD_BIT]) begin
                // DI only on the transition into writing
                if ((shadow_di_en || new_di) && !shadow_writing) res.di = 1'b1;
                shadow_reading = 1'b0;
                shadow_writing = 1'b1;
            end else begin
                shadow_reading = 1'b1;
                shadow_writing = 1'b0;
            end
            st = st | ST_BUSY;
            shadow_si_en = new_si;
            shadow_di_en = new_di;
        end
        // every class, decoded or not, recomputes not-ready
        if (shadow_reading) st = (rx_bytes.size() == 0) ? (st | ST_NRDY) : (st & ~ST_NRDY);
        if (shadow_writing) begin
            st = (tx_bytes.size() >= CCR_FIFO_DEPTH) ? (st | ST_NRDY) : (st & ~ST_NRDY);
        end
        shadow_status = st;
    endfunction

    // Advance the shadow state by one accepted word and return its result.
    function automatic t_console_result console_step(input logic [CMD_W-1:0] code,
                                                     input logic [WORD_W-1:0] w);
        t_console_result   res;
        logic [WORD_W-1:0] st;
        res = '0;
        case (code)
            CMD_DATA_WR: begin
                if (tx_bytes.size() >= CCR_FIFO_DEPTH) res.ovf = 1'b1;
                else tx_bytes.push_back(w[7:0]);
                if (shadow_writing && tx_bytes.size() != 0) shadow_status |= ST_NRDY;
            end
            CMD_CTRL_WR: apply_command(w, res);
            CMD_DATA_RD: begin
                if (rx_bytes.size() != 0) res.rv = {8'h00, rx_bytes.pop_front()};
                if (shadow_reading && rx_bytes.size() == 0) shadow_status |= ST_NRDY;
            end
            CMD_STAT_RD: begin
                st = shadow_status;
                if (shadow_reading) begin
                    st = (rx_bytes.size() == 0) ? (st | ST_NRDY) : (st & ~ST_NRDY);
                end
                if (shadow_writing) begin
                    st = (tx_bytes.size() != 0) ? (st | ST_NRDY) : (st & ~ST_NRDY);
                end
                shadow_status = st;
                res.rv = st;
            end
            CMD_LINE_RX: begin
                // taken only while reading with nothing held; echo it back
                if (shadow_reading && rx_bytes.size() == 0) begin
                    rx_bytes.push_back(w[7:0]);
                    res.acc = 1'b1;
                    shadow_status &= ~ST_NRDY;
                    res.di  = shadow_di_en;
                    res.txv = 1'b1;
                    res.txb = w[7:0];
                end
            end
            CMD_TX_PULL: begin
                if (tx_bytes.size() != 0) begin
                    res.txb = tx_bytes.pop_front();
                    res.txv = 1'b1;
                    if (tx_bytes.size() == 0 && shadow_writing) begin
                        shadow_status &= ~ST_NRDY;
                        res.di = shadow_di_en;
                    end
                end else if (shadow_writing) begin
                    shadow_status &= ~ST_NRDY;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("mismatch on result %0d, %s: got %h, expected %h",
                     results_seen, what, got, want);
        end
    endtask

    // Check results and predict accepted words; both sampled at the same edge
    // as the block, so the values seen here are the pre-edge ones.
    always @(posedge i_clk) begin : result_check
        t_console_result got;
        t_console_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_console_result'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", got.rv, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.rv !== want.rv) report_mismatch("read_value", got.rv, want.rv);
                    if (got.si !== want.si) begin
                        report_mismatch("service_irq", WORD_W'(got.si), WORD_W'(want.si));
                    end
                    if (got.di !== want.di) begin
                        report_mismatch("data_irq", WORD_W'(got.di), WORD_W'(want.di));
                    end
                    if (got.txv !== want.txv) begin
                        report_mismatch("line_tx_valid", WORD_W'(got.txv), WORD_W'(want.txv));
                    end
                    if (got.txb !== want.txb) begin
                        report_mismatch("line_tx_byte", WORD_W'(got.txb), WORD_W'(want.txb));
                    end
                    if (got.acc !== want.acc) begin
                        report_mismatch("rx_accepted", WORD_W'(got.acc), WORD_W'(want.acc));
                    end
                    if (got.ovf !== want.ovf) begin
                        report_mismatch("overflow", WORD_W'(got.ovf), WORD_W'(want.ovf));
                    end
                    if (got.pad !== want.pad) begin
                        report_mismatch("zero pad", WORD_W'(got.pad), WORD_W'(want.pad));
                    end
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(console_step(s_axis_tuser, s_axis_tdata));
            end
        end
    end

    // Count down a requested hold-off of the receiver.
    always @(posedge i_clk) begin
        if (hold_start) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // Receiver: stall at random, and hold low for the whole hold-off.
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_start && hold_left == 0
                         && ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("console_controller_registers regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word and hold it until accepted; idle before it at random.
    task automatic send_word(input logic [CMD_W-1:0] code, input logic [WORD_W-1:0] w);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= code;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Hit reset state, the empty and held cases, every command and the spare codes.
    task automatic test_directed();
        send_word(CMD_STAT_RD, 16'h0000);   // reset status
        send_word(CMD_DATA_RD, 16'hffff);   // empty receive FIFO reads zero
        send_word(CMD_LINE_RX, 16'h00ff);   // not reading: ignored
        send_word(CMD_TX_PULL, 16'h0000);   // empty transmit FIFO
        send_word(CMD_SPARE_LO, 16'hffff);
        send_word(CMD_SPARE_HI, 16'h5a5a);
        send_word(CMD_CTRL_WR, 16'h0000);   // undecoded class, low
        send_word(CMD_CTRL_WR, 16'hffff);   // undecoded class, high
        send_word(CMD_CTRL_WR, 16'h5000);   // no-op, enable SI
        send_word(CMD_CTRL_WR, 16'h5124);   // break detect with SI release
        send_word(CMD_CTRL_WR, 16'h4100);   // break select, detect off
        send_word(CMD_CTRL_WR, 16'h4400);   // terminate; SI enable already off, so no SI
        send_word(CMD_CTRL_WR, 16'ha800);   // read transfer, DI on
        send_word(CMD_STAT_RD, 16'h0000);
        send_word(CMD_LINE_RX, 16'hffab);   // accepted and echoed
        send_word(CMD_LINE_RX, 16'h0012);   // byte still held: ignored
        send_word(CMD_STAT_RD, 16'hffff);
        send_word(CMD_DATA_RD, 16'h0000);
        send_word(CMD_CTRL_WR, 16'ha000);   // write transfer, DI on
        send_word(CMD_DATA_WR, 16'hffff);
        send_word(CMD_DATA_WR, 16'h0000);
        send_word(CMD_STAT_RD, 16'h0000);
        send_word(CMD_TX_PULL, 16'h0000);
        send_word(CMD_TX_PULL, 16'hffff);   // last byte: DI
        send_word(CMD_CTRL_WR, 16'h7400);   // terminate
        drain_results();
    endtask

    // Mostly well-formed sessions with random content, plus raw noise.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned n_words);
        int unsigned       start;
        int unsigned       burst;
        logic [WORD_W-1:0] cw;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start = words_sent;
        while (words_sent - start < n_words) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    // write session; one in four bursts runs 60 to 70 words, around the FIFO depth
                    cw = {CLS_XFER, 14'($urandom)};
                    cw[B_DIRRD_BIT] = 1'b0;
                    send_word(CMD_CTRL_WR, cw);
                    burst = ($urandom_range(3) == 0) ? $urandom_range(60, 70)
                                                     : $urandom_range(1, 8);
                    repeat (burst) begin
                        send_word(CMD_DATA_WR, 16'($urandom));
                        if ($urandom_range(3) == 0) send_word(CMD_STAT_RD, 16'($urandom));
                    end
                    repeat (burst + $urandom_range(2) - 1) begin
                        send_word(CMD_TX_PULL, 16'($urandom));
                        if ($urandom_range(3) == 0) send_word(CMD_STAT_RD, 16'($urandom));
                    end
                    if ($urandom_range(1) == 0) begin
                        cw = {CLS_CTRL, 14'($urandom)};
                        cw[B_TERM_BIT] = 1'b1;
                        send_word(CMD_CTRL_WR, cw);
                    end
                end
                4, 5, 6: begin
                    // read session: receive, maybe a second byte, read back
                    cw = {CLS_XFER, 14'($urandom)};
                    cw[B_DIRRD_BIT] = 1'b1;
                    send_word(CMD_CTRL_WR, cw);
                    repeat ($urandom_range(1, 6)) begin
                        send_word(CMD_LINE_RX, 16'($urandom));
                        if ($urandom_range(3) == 0) send_word(CMD_LINE_RX, 16'($urandom));
                        if ($urandom_range(1) == 0) send_word(CMD_STAT_RD, 16'($urandom));
                        send_word(CMD_DATA_RD, 16'($urandom));
                        if ($urandom_range(3) == 0) send_word(CMD_DATA_RD, 16'($urandom));
                    end
                end
                7: begin
                    // command words of any class; keep most control words no-ops
                    cw = 16'($urandom);
                    if (cw[15:14] == CLS_CTRL && $urandom_range(1) == 0) cw[B_TERM_BIT] = 1'b0;
                    send_word(CMD_CTRL_WR, cw);
                    send_word(CMD_STAT_RD, 16'($urandom));
                end
                default: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_word(3'($urandom_range(7)), 16'($urandom));
                    end
                end
            endcase
        end
        drain_results();
    endtask

    // Hold the receiver off while words keep coming so the block stalls its input.
    task automatic test_backpressure();
        logic [WORD_W-1:0] cw;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        cw = {CLS_XFER, 14'($urandom)};
        cw[B_DIRRD_BIT] = 1'b0;
        send_word(CMD_CTRL_WR, cw);
        repeat (30) begin
            send_word(3'($urandom_range(CMD_DATA_WR, CMD_TX_PULL)), 16'($urandom));
        end
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(0, 0, 140);
        test_random_traffic(53, 0, 140);
        test_random_traffic(0, 53, 140);
        test_random_traffic(6, 6, 140);
        test_backpressure();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("console_controller_registers regression: pass");
        end else begin
            $display("console_controller_registers regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ccr_pkg.sv
hw/rtl/ccr_fifo.sv
hw/rtl/ccr_ctrl.sv
hw/rtl/console_controller_registers.sv
test/console_controller_registers_test.sv
